FILE: src/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [255:0] SM3_IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7,
		32'hDA8A0600, 32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

	typedef struct packed {
		logic [31:0] msg_word;
		logic [2:0]  valid_bytes;
		logic        last_word;
	} in_req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} out_req_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic       put;        // write one byte into the buffer
		logic [7:0] put_byte;
		logic       len_add;    // add 8 to the bit length
		logic       snap_len;   // capture length for padding
		logic       rnd_start;  // load working registers
		logic       rnd_step;   // one compression round
		logic       rnd_fold;   // xor result into chaining value
		logic       clear;      // reset byte count, length and chaining value
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0]  byte_cnt;
		logic [63:0] len_snap;
		logic [5:0]  round;
	} dp_stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

FILE: src/sm3_datapath.sv
// ----------------------------------------------------------------------------
// SM3 datapath
// Block buffer, rolling message schedule, round logic and chaining value.
// ----------------------------------------------------------------------------
module sm3_datapath import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [255:0] cv
);

	logic [31:0] buf_q [16];
	logic [31:0] w_q [16];
	logic [5:0]  cnt_q;
	logic [63:0] len_q, snap_q;
	logic [5:0]  rnd_q;
	logic [255:0] cv_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

	logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wn;
	logic [7:0]  sh;

	always_comb begin
		tj  = (rnd_q < 6'd16) ? T_LOW : T_HIGH;
		a12 = rotl(a_q, 5'd12);
		ss1 = rotl(a12 + e_q + rotl(tj, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ff = a_q ^ b_q ^ c_q;
			gg = e_q ^ f_q ^ g_q;
		end else begin
			ff = (a_q & b_q) | (a_q & c_q) | (b_q & c_q);
			gg = (e_q & f_q) | (~e_q & g_q);
		end
		tt1 = ff + d_q + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + h_q + ss1 + w_q[0];
		wn  = p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
		sh  = 8'd24 - {3'd0, cnt_q[1:0], 3'd0};
	end

	always_ff @(posedge clk) begin
		if (cmd.put)
			buf_q[cnt_q[5:2]] <= (buf_q[cnt_q[5:2]] & ~(32'hFF << sh))
				| ({24'd0, cmd.put_byte} << sh);
		if (cmd.rnd_start) begin
			for (int i = 0; i < 16; i++)
				w_q[i] <= buf_q[i];
		end else if (cmd.rnd_step) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			len_q  <= '0;
			snap_q <= '0;
			rnd_q  <= '0;
			cv_q   <= SM3_IV;
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= SM3_IV;
		end else begin
			if (cmd.clear) begin
				cnt_q <= '0;
				len_q <= '0;
				cv_q  <= SM3_IV;
			end else begin
				if (cmd.put)
					cnt_q <= cnt_q + 6'd1;
				if (cmd.len_add)
					len_q <= len_q + 64'd8;
			end
			if (cmd.snap_len)
				snap_q <= len_q;
			if (cmd.rnd_start) begin
				rnd_q <= '0;
				{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= cv_q;
			end else if (cmd.rnd_step) begin
				rnd_q <= rnd_q + 6'd1;
				d_q <= c_q; c_q <= rotl(b_q, 5'd9); b_q <= a_q; a_q <= tt1;
				h_q <= g_q; g_q <= rotl(f_q, 5'd19); f_q <= e_q; e_q <= p0(tt2);
			end
			if (cmd.rnd_fold)
				cv_q <= cv_q ^ {a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q};
		end
	end

	assign stat = '{byte_cnt: cnt_q, len_snap: snap_q, round: rnd_q};
	assign cv   = cv_q;

endmodule

FILE: src/sm3_ctrl.sv
// ----------------------------------------------------------------------------
// SM3 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sm3_ctrl import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_req_t     in_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_idx,
	output dp_cmd_t     cmd,
	input  dp_stat_t    stat
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BYTE = 3'd1;
	localparam logic [2:0] ST_PAD  = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_FOLD = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] word_q;
	logic [2:0]  nb_q, bi_q, oi_q;
	logic        last_q, pad_q;
	logic [3:0]  pi_q;
	logic        start_q;
	logic [2:0]  nb_in;
	logic [7:0]  pb;
	logic        full;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_idx   = oi_q;
	assign nb_in     = (in_req.valid_bytes > 3'd4) ? 3'd4 : in_req.valid_bytes;
	assign full      = (stat.byte_cnt == 6'd63);

	always_comb begin
		case (pi_q)
			4'd0:    pb = PAD_BYTE;
			4'd1:    pb = 8'd0;
			default: pb = stat.len_snap[8'd63 - {pi_q - 4'd2, 3'd0} -: 8];
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_BYTE: begin
				cmd.put      = (start_q == 1'b0);
				cmd.put_byte = word_q[31 - {bi_q[1:0], 3'd0} -: 8];
				cmd.len_add  = 1'b1;
			end
			ST_PAD: begin
				cmd.put      = (start_q == 1'b0);
				cmd.put_byte = pb;
			end
			ST_RND:  cmd.rnd_step = 1'b1;
			ST_FOLD: cmd.rnd_fold = 1'b1;
			ST_OUT:  cmd.clear = out_ready && (oi_q == 3'd7);
			default: cmd = '0;
		endcase
		if (start_q)
			cmd.rnd_start = 1'b1;
		if (state_q == ST_BYTE && start_q) begin
			cmd.len_add = 1'b0;
		end
		if (state_q == ST_PAD && pi_q == 4'd0 && !start_q)
			cmd.snap_len = 1'b1;
	end

	// Bytes: after each full block, start_q marks one cycle to load the schedule.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bi_q    <= '0;
			nb_q    <= '0;
			last_q  <= 1'b0;
			pad_q   <= 1'b0;
			pi_q    <= '0;
			oi_q    <= '0;
			start_q <= 1'b0;
			word_q  <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						word_q <= in_req.msg_word;
						nb_q   <= nb_in;
						last_q <= in_req.last_word;
						bi_q   <= '0;
						pi_q   <= '0;
						if (nb_in != 3'd0)
							state_q <= ST_BYTE;
						else if (in_req.last_word)
							state_q <= ST_PAD;
					end
				end
				ST_BYTE: begin
					if (start_q) begin
						state_q <= ST_RND;
					end else begin
						bi_q <= bi_q + 3'd1;
						if (full) begin
							start_q <= 1'b1;
							pad_q   <= 1'b0;
						end else if (bi_q + 3'd1 == nb_q) begin
							state_q <= last_q ? ST_PAD : ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					if (start_q) begin
						state_q <= ST_RND;
					end else begin
						if (pi_q == 4'd0 && stat.byte_cnt == 6'd55)
							pi_q <= 4'd2;
						else if (pi_q == 4'd1 && stat.byte_cnt != 6'd55)
							pi_q <= 4'd1;
						else
							pi_q <= pi_q + 4'd1;
						if (full) begin
							start_q <= 1'b1;
							pad_q   <= 1'b1;
						end
					end
				end
				ST_RND: begin
					if (stat.round == 6'd63)
						state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					if (!pad_q) begin
						if (bi_q == nb_q)
							state_q <= last_q ? ST_PAD : ST_IDLE;
						else
							state_q <= ST_BYTE;
					end else if (pi_q == 4'd10) begin
						oi_q    <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						oi_q <= oi_q + 3'd1;
						if (oi_q == 3'd7)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("output and input both open");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND) |-> !cmd.put)
		else $error("buffer written during rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> (oi_q == 3'd7))
		else $error("clear before last digest word");

endmodule

FILE: src/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Hashes one byte-packed message at a time and returns the 256-bit digest.
// ----------------------------------------------------------------------------
// A request on the input channel carries up to four big-endian bytes; the
// word flagged last_word ends the message. Bytes enter the block buffer one
// at a time, and every full 64-byte block is then compressed: the message
// schedule is loaded, 64 rounds run through the single round unit and the
// result is folded into the chaining value. On the last word the padding
// bytes go in one a cycle while no block is being compressed, one or two
// more blocks are compressed, and then the eight digest words leave on the
// output channel, most significant first, one per cycle while out_ready is
// high. A stalled receiver simply holds the block in its output state; no
// input is taken until the last digest word is gone. Reset loads the
// initial vector and clears the length and the byte count; the block
// buffer needs no clearing.
// ----------------------------------------------------------------------------
module sm3_hash_engine import sm3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_req_t   in_req,
	output logic      out_valid,
	input  logic      out_ready,
	output out_req_t  out_req
);

	dp_cmd_t      cmd;
	dp_stat_t     stat;
	logic [255:0] cv;
	logic [2:0]   idx;

	sm3_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_req,
		.out_valid, .out_ready, .out_idx(idx), .cmd, .stat
	);

	sm3_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .cv
	);

	assign out_req.digest_word = cv[255 - {idx, 5'd0} -: 32];
	assign out_req.word_index  = idx;
	assign out_req.digest_last = (idx == 3'd7);

endmodule
